// ===== design/small_blob_removal_8conn_assert.svh =====
// Assertion macros for the small blob removal block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SMALL_BLOB_REMOVAL_8CONN_ASSERT_SVH
`define SMALL_BLOB_REMOVAL_8CONN_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define SBR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SBR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/sbr_pkg.sv =====
// Package for the small blob removal block: codes, defaults and neighbour tables.
// No dependencies.
`timescale 1ns / 1ps
package sbr_pkg;

  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 512;
  localparam int unsigned CfgDataW     = 19;

  localparam logic [9:0]  FrameWidthRst  = 10'd512;
  localparam logic [9:0]  FrameHeightRst = 10'd512;
  localparam logic [18:0] MinAreaRst     = 19'd1;
  localparam logic [7:0]  FgThreshRst    = 8'd100;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MIN_AREA     = 2'd2,
    REG_FG_THRESHOLD = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_FIN,
    ST_ER_RD,
    ST_ER_WR,
    ST_DONE
  } state_e;

  // Column step of neighbour d: -1, 0 or +1.
  function automatic logic signed [1:0] dcol(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0, 3'd1, 3'd7: v = -2'sd1;
      3'd3, 3'd4, 3'd5: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  // Row step of neighbour d: -1, 0 or +1.
  function automatic logic signed [1:0] drow(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd1, 3'd2, 3'd3: v = -2'sd1;
      3'd5, 3'd6, 3'd7: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/small_blob_removal_8conn.sv =====
// Small blob removal by 8-connected area opening, top level.
// Depends on sbr_pkg and small_blob_removal_8conn_assert.svh.
//
// Usage: requests enter on in_valid_i/in_stall_o with command_i, col_i, row_i
// and pixel_in_i. A write stores one pixel. A read raises out_valid_o with
// kind_o 0 via ST_RDOUT; the next read is taken once that result has left.
// A start request clears all 2^(CW+RW) entries of the visited map, one entry
// per cycle, scans the active frame column by column, floods each unvisited
// foreground component breadth first and zeroes those smaller than min_area.
// It then answers with kind_o 1 and pixel_out_o 0. A run goes through the
// clearing sweep, a read and a check per scanned pixel and per in-frame
// neighbour probe, a skip per out-of-frame direction, a pop read and a wait
// per member popped, an empty pop and the area check per component, and a
// read and a write per erased pixel: every step is bound by the single read
// port of each memory. Writes keep flowing while a result waits on a stalled
// receiver; reads and starts wait until the output register is free.
// Configuration is written on the plain port cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write it only while the block is idle, which the block does
// not enforce. Reset returns the registers to their defaults and the
// controller to idle; pixel contents are undefined until written.
`timescale 1ns / 1ps
`include "small_blob_removal_8conn_assert.svh"
module small_blob_removal_8conn
  import sbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [8:0]          col_i,
  input  logic [8:0]          row_i,
  input  logic [7:0]          pixel_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [7:0]          pixel_out_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned Depth = 1 << AW;

  // configuration registers
  logic [9:0]  fw_q, fh_q;
  logic [18:0] min_area_q;
  logic [7:0]  thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FrameWidthRst;
      fh_q       <= FrameHeightRst;
      min_area_q <= MinAreaRst;
      thr_q      <= FgThreshRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i[9:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[9:0];
        REG_MIN_AREA:     min_area_q <= cfg_data_i;
        REG_FG_THRESHOLD: thr_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  logic [CW:0] w_sat;
  logic [RW:0] h_sat;
  always_comb begin
    w_sat = (32'(fw_q) > MAX_WIDTH)  ? (CW+1)'(MAX_WIDTH)  : (CW+1)'(fw_q);
    h_sat = (32'(fh_q) > MAX_HEIGHT) ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(fh_q);
  end

  // request decode
  logic          in_acc, in_inside;
  logic [AW-1:0] in_addr;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_inside = (32'(col_i) < MAX_WIDTH) && (32'(row_i) < MAX_HEIGHT);
  assign in_addr   = {RW'(row_i), CW'(col_i)};

  // control registers
  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW:0]   sc_q, sc_d;
  logic [RW-1:0] sr_q, sr_d;
  logic [AW:0]   head_q, head_d, tail_q, tail_d, k_q, k_d, size_q, size_d;
  logic [CW-1:0] cc_q, cc_d;
  logic [RW-1:0] cr_q, cr_d;
  logic [2:0]    dir_q, dir_d;
  logic          inside_q, inside_d;
  logic          out_valid_q, out_valid_d, kind_q, kind_d;
  logic [7:0]    pout_q, pout_d;

  // memory ports
  logic          pix_we, pix_re, vis_we, vis_wdata, q_we, q_re;
  logic [AW-1:0] pix_waddr, mem_raddr, vis_waddr, q_waddr, q_raddr, q_wdata;
  logic [7:0]    pix_wdata, pix_rdata_q;
  logic          vis_rdata_q;
  logic [AW-1:0] q_rdata_q;
  logic [7:0]    pix_mem [Depth];
  logic          vis_mem [Depth];
  logic [AW-1:0] q_mem   [Depth];

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    if (pix_re) pix_rdata_q <= pix_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    if (pix_re) vis_rdata_q <= vis_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rdata_q <= q_mem[q_raddr];
  end

  // neighbour of the current member
  logic signed [1:0] dc, dr;
  logic              nb_ok;
  logic [CW-1:0]     nc;
  logic [RW-1:0]     nr;
  logic              seed_last_row;
  always_comb begin
    dc = dcol(dir_q);
    dr = drow(dir_q);
    nb_ok = 1'b1;
    nc = cc_q;
    nr = cr_q;
    if (dc == -2'sd1) begin
      nb_ok = nb_ok && (cc_q != '0);
      nc = cc_q - 1'b1;
    end else if (dc == 2'sd1) begin
      nb_ok = nb_ok && (({1'b0, cc_q} + 1'b1) < w_sat);
      nc = cc_q + 1'b1;
    end
    if (dr == -2'sd1) begin
      nb_ok = nb_ok && (cr_q != '0);
      nr = cr_q - 1'b1;
    end else if (dr == 2'sd1) begin
      nb_ok = nb_ok && (({1'b0, cr_q} + 1'b1) < h_sat);
      nr = cr_q + 1'b1;
    end
    seed_last_row = ({1'b0, sr_q} + 1'b1) == h_sat;
  end

  // controller: next state, memory controls and output register
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;  sc_d = sc_q;  sr_d = sr_q;
    head_d = head_q;  tail_d = tail_q;  k_d = k_q;  size_d = size_q;
    cc_d = cc_q;  cr_d = cr_q;  dir_d = dir_q;  inside_d = inside_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d = kind_q;  pout_d = pout_q;
    pix_we = 1'b0;  pix_waddr = in_addr;  pix_wdata = pixel_in_i;
    pix_re = 1'b0;  mem_raddr = in_addr;
    vis_we = 1'b0;  vis_waddr = clr_q;  vis_wdata = 1'b0;
    q_we = 1'b0;  q_waddr = tail_q[AW-1:0];  q_wdata = {sr_q, sc_q[CW-1:0]};
    q_re = 1'b0;  q_raddr = head_q[AW-1:0];
    in_stall_o = (state_q != ST_IDLE) || (out_valid_q && (command_i != CMD_WRITE));

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(command_i))
            CMD_WRITE: pix_we = in_inside;
            CMD_READ: begin
              pix_re = 1'b1;
              inside_d = in_inside;
              state_d = ST_RDOUT;
            end
            CMD_START: begin
              clr_d = '0;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_RDOUT: begin
        out_valid_d = 1'b1;
        kind_d = 1'b0;
        pout_d = inside_q ? pix_rdata_q : 8'd0;
        state_d = ST_IDLE;
      end
      // sweep the visited map to zero
      ST_CLEAR: begin
        vis_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) begin
          sc_d = '0;
          sr_d = '0;
          state_d = (w_sat == '0 || h_sat == '0) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sc_q >= w_sat) begin
          state_d = ST_DONE;
        end else begin
          pix_re = 1'b1;
          mem_raddr = {sr_q, sc_q[CW-1:0]};
          state_d = ST_SCAN_CHK;
        end
      end
      // seed a new component or advance the scan
      ST_SCAN_CHK: begin
        if (vis_rdata_q || pix_rdata_q <= thr_q) begin
          state_d = ST_SCAN_RD;
          if (seed_last_row) begin
            sr_d = '0;
            sc_d = sc_q + 1'b1;
          end else begin
            sr_d = sr_q + 1'b1;
          end
        end else begin
          vis_we = 1'b1;
          vis_waddr = {sr_q, sc_q[CW-1:0]};
          vis_wdata = 1'b1;
          q_we = 1'b1;
          q_waddr = '0;
          head_d = '0;
          tail_d = (AW+1)'(1);
          size_d = '0;
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        if (head_q == tail_q) begin
          state_d = ST_FIN;
        end else begin
          q_re = 1'b1;
          head_d = head_q + 1'b1;
          size_d = size_q + 1'b1;
          state_d = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cc_d = q_rdata_q[CW-1:0];
        cr_d = q_rdata_q[AW-1:CW];
        dir_d = '0;
        state_d = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (nb_ok) begin
          pix_re = 1'b1;
          mem_raddr = {nr, nc};
          state_d = ST_NB_CHK;
        end else begin
          dir_d = dir_q + 1'b1;
          if (dir_q == 3'd7) state_d = ST_POP_RD;
        end
      end
      // enqueue an unvisited foreground neighbour
      ST_NB_CHK: begin
        if (!vis_rdata_q && pix_rdata_q > thr_q) begin
          vis_we = 1'b1;
          vis_waddr = {nr, nc};
          vis_wdata = 1'b1;
          q_we = 1'b1;
          q_wdata = {nr, nc};
          tail_d = tail_q + 1'b1;
        end
        dir_d = dir_q + 1'b1;
        state_d = (dir_q == 3'd7) ? ST_POP_RD : ST_NB_RD;
      end
      ST_FIN: begin
        if (32'(size_q) < 32'(min_area_q)) begin
          k_d = '0;
          state_d = ST_ER_RD;
        end else begin
          state_d = ST_SCAN_RD;
          if (seed_last_row) begin
            sr_d = '0;
            sc_d = sc_q + 1'b1;
          end else begin
            sr_d = sr_q + 1'b1;
          end
        end
      end
      ST_ER_RD: begin
        q_re = 1'b1;
        q_raddr = k_q[AW-1:0];
        state_d = ST_ER_WR;
      end
      // zero one member of a small component
      ST_ER_WR: begin
        pix_we = 1'b1;
        pix_waddr = q_rdata_q;
        pix_wdata = 8'd0;
        k_d = k_q + 1'b1;
        if (k_q + 1'b1 == tail_q) begin
          state_d = ST_SCAN_RD;
          if (seed_last_row) begin
            sr_d = '0;
            sc_d = sc_q + 1'b1;
          end else begin
            sr_d = sr_q + 1'b1;
          end
        end else begin
          state_d = ST_ER_RD;
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        kind_d = 1'b1;
        pout_d = 8'd0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_q       <= '0;
      sc_q        <= '0;
      sr_q        <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      k_q         <= '0;
      size_q      <= '0;
      dir_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sc_q        <= sc_d;
      sr_q        <= sr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      k_q         <= k_d;
      size_q      <= size_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cc_q     <= cc_d;
    cr_q     <= cr_d;
    inside_q <= inside_d;
    kind_q   <= kind_d;
    pout_q   <= pout_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign pixel_out_o = pout_q;

  `SBR_ASSERT_ALWAYS(a_head_le_tail, head_q <= tail_q, "queue head passed tail")
  `SBR_ASSERT_ALWAYS(a_take_idle, !in_acc || state_q == ST_IDLE, "request taken while busy")
  `SBR_ASSERT_ALWAYS(a_done_zero, !(out_valid_q && kind_q) || pout_q == 8'd0, "done carries data")
  `SBR_ASSERT_NEXT(a_done_out, state_q == ST_DONE, out_valid_q && kind_q, "done not reported")

endmodule

// ===== dv/tb_small_blob_removal_8conn.sv =====
// Self-checking testbench for small_blob_removal_8conn: loads small frames, runs the
// 8-connected area opening and reads pixels back against an in-bench flood-fill model.
// Depends on sbr_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_small_blob_removal_8conn;
  import sbr_pkg::*;

  localparam int unsigned Cells = MaxWidthDef * MaxHeightDef;

  typedef struct {
    cmd_e       cmd;
    logic [8:0] col;
    logic [8:0] row;
    logic [7:0] pix;
  } pix_req_t;

  typedef struct {
    logic       kind;
    logic [7:0] pix;
  } pix_resp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          command = '0;
  logic [8:0]          col = '0;
  logic [8:0]          row = '0;
  logic [7:0]          pixel_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                kind;
  logic [7:0]          pixel_out;

  small_blob_removal_8conn dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .command_i  (command),
    .col_i      (col),
    .row_i      (row),
    .pixel_in_i (pixel_in),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .kind_o     (kind),
    .pixel_out_o(pixel_out)
  );

  // Model state and configuration copy
  logic [7:0]  img [Cells];
  bit          seen [Cells];
  int unsigned ring [Cells];
  int unsigned frame_w = 512, frame_h = 512, min_area = 1, fg_thresh = 100;

  // Stimulus-side bookkeeping: which pixels hold a value
  bit          written [Cells];
  int unsigned written_list [$];

  pix_req_t    pending_q [$];
  pix_resp_t   expected_q [$];
  bit          taken;
  int unsigned idle_pct = 37;
  int unsigned mismatches = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Flood every unvisited foreground pixel and erase small components
  task automatic filter_frame();
    int dc [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    int dr [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
    int w, h, head, tail, cnt, nc, nr, ni, cur;
    w = (frame_w > 512) ? 512 : frame_w;
    h = (frame_h > 512) ? 512 : frame_h;
    for (int i = 0; i < Cells; i++) seen[i] = 1'b0;
    for (int c = 0; c < w; c++) begin
      for (int r = 0; r < h; r++) begin
        cur = r * 512 + c;
        if (seen[cur] || img[cur] <= fg_thresh) continue;
        seen[cur] = 1'b1;
        head = 0;
        tail = 1;
        ring[0] = cur;
        cnt = 0;
        while (head < tail) begin
          cur = ring[head];
          head++;
          cnt++;
          for (int d = 0; d < 8; d++) begin
            nc = cur % 512 + dc[d];
            nr = cur / 512 + dr[d];
            if (nc < 0 || nr < 0 || nc >= w || nr >= h) continue;
            ni = nr * 512 + nc;
            if (seen[ni]) continue;
            if (img[ni] > fg_thresh) begin
              seen[ni] = 1'b1;
              ring[tail] = ni;
              tail++;
            end
          end
        end
        if (cnt < min_area)
          for (int k = 0; k < tail; k++) img[ring[k]] = 8'd0;
      end
    end
  endtask

  task automatic predict_request(input pix_req_t rq);
    int unsigned addr;
    addr = rq.row * 512 + rq.col;
    case (rq.cmd)
      CMD_WRITE: img[addr] = rq.pix;
      CMD_START: begin
        filter_frame();
        expected_q.push_back('{kind: 1'b1, pix: 8'd0});
      end
      CMD_READ: expected_q.push_back('{kind: 1'b0, pix: img[addr]});
      default: ;
    endcase
  endtask

  // Record a taken request and update the model
  always @(posedge clk) begin
    pix_req_t rq;
    if (rst_n && in_valid && !in_stall) begin
      rq.cmd = cmd_e'(command);
      rq.col = col;
      rq.row = row;
      rq.pix = pixel_in;
      predict_request(rq);
      taken = 1'b1;
    end
  end

  // Present the next request after the current one is taken
  always @(negedge clk) begin
    pix_req_t rq;
    if (rst_n && (!in_valid || taken)) begin
      taken = 1'b0;
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        rq = pending_q.pop_front();
        in_valid <= 1'b1;
        command  <= rq.cmd;
        col      <= rq.col;
        row      <= rq.row;
        pixel_in <= rq.pix;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    pix_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d pixel %0d", kind, pixel_out);
      end else begin
        want = expected_q.pop_front();
        if (kind !== want.kind || pixel_out !== want.pix) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kind %0d pixel %0d, got kind %0d pixel %0d",
                     want.kind, want.pix, kind, pixel_out);
        end
      end
    end
  end

  task automatic push_req(input cmd_e cmd, input int unsigned c, input int unsigned r,
                          input int unsigned p);
    int unsigned addr;
    addr = r * 512 + c;
    if (cmd == CMD_WRITE && !written[addr]) begin
      written[addr] = 1'b1;
      written_list.push_back(addr);
    end
    pending_q.push_back('{cmd: cmd, col: c[8:0], row: r[8:0], pix: p[7:0]});
  endtask

  task automatic write_reg(input reg_e idx, input int unsigned val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CfgDataW-1:0];
    case (idx)
      REG_FRAME_WIDTH:  frame_w   = val & 10'h3FF;
      REG_FRAME_HEIGHT: frame_h   = val & 10'h3FF;
      REG_MIN_AREA:     min_area  = val & 19'h7FFFF;
      default:          fg_thresh = val & 8'hFF;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned area,
                           input int unsigned thr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_MIN_AREA, area);
    write_reg(REG_FG_THRESHOLD, thr);
  endtask

  // Hold the sender until every request is taken and every result has come
  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  // Fill the active frame, each pixel above or not above the threshold by a coin flip
  task automatic fill_frame();
    int unsigned p;
    for (int c = 0; c < frame_w && c < 512; c++)
      for (int r = 0; r < frame_h && r < 512; r++) begin
        if ($urandom_range(1)) p = (fg_thresh < 255) ? $urandom_range(255, fg_thresh + 1) : 255;
        else p = $urandom_range(fg_thresh, 0);
        push_req(CMD_WRITE, c, r, p);
      end
  endtask

  task automatic read_any();
    int unsigned addr;
    addr = written_list[$urandom_range(written_list.size() - 1)];
    push_req(CMD_READ, addr % 512, addr / 512, $urandom_range(255));
  endtask

  initial begin
    int unsigned op;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: store corners, unused command, a small frame with erasing
    configure(8, 6, 3, 100);
    push_req(CMD_WRITE, 511, 511, 255);
    push_req(CMD_WRITE, 0, 511, 0);
    push_req(CMD_READ, 511, 511, 0);
    push_req(CMD_READ, 0, 511, 255);
    push_req(CMD_NONE, 511, 511, 255);
    fill_frame();
    push_req(CMD_WRITE, 0, 0, 255);
    push_req(CMD_WRITE, 7, 5, 101);
    push_req(CMD_WRITE, 3, 2, 100);
    push_req(CMD_START, 0, 0, 0);
    push_req(CMD_READ, 0, 0, 0);
    push_req(CMD_READ, 7, 5, 0);
    push_req(CMD_READ, 3, 2, 0);
    drain();

    // Zero width with saturated height, then saturated width with zero height
    configure(0, 1023, 0, 0);
    push_req(CMD_START, 0, 0, 0);
    push_req(CMD_READ, 511, 511, 0);
    drain();
    configure(1023, 0, 19'h7FFFF, 255);
    push_req(CMD_START, 0, 0, 0);
    push_req(CMD_READ, 0, 0, 0);
    drain();

    // Random rounds: full frame load, mixed traffic, one filter run each
    for (int rnd = 0; rnd < 4; rnd++) begin
      idle_pct = (rnd == 1) ? 0 : 37;
      configure((rnd == 3) ? 16 : $urandom_range(16, 1), (rnd == 3) ? 16 : $urandom_range(16, 1),
                (rnd == 2) ? 0 : $urandom_range(8, 1), $urandom_range(255));
      fill_frame();
      for (int i = 0; i < 180; i++) begin
        op = $urandom_range(99);
        if (op < 50) read_any();
        else if (op < 70)
          push_req(CMD_WRITE, $urandom_range(frame_w - 1), $urandom_range(frame_h - 1),
                   $urandom_range(255));
        else if (op < 95)
          push_req(CMD_WRITE, $urandom_range(511), $urandom_range(511), $urandom_range(255));
        else push_req(CMD_NONE, $urandom_range(511), $urandom_range(511), $urandom_range(255));
      end
      push_req(CMD_START, $urandom_range(511), $urandom_range(511), $urandom_range(255));
      for (int i = 0; i < 20; i++) read_any();
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_small_blob_removal_8conn: PASS");
    end else begin
      $display("tb_small_blob_removal_8conn: FAIL");
    end
    $finish;
  end

  // Guard against a hung run
  initial begin
    #200_000_000;
    $display("tb_small_blob_removal_8conn: FAIL");
    $finish;
  end

endmodule
